// ----- rtl/rsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rsi_pkg: shared widths and types for the ray/sphere intersection pipeline
// Widths of every intermediate follow from the coordinate and fraction widths.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int CW   = 16;               // coordinate width
	localparam int FW   = 8;                // fraction bits of the hit point
	localparam int OW   = CW + FW;          // hit point width
	localparam int WW   = CW + 1;           // eye - center
	localparam int RDW  = CW - 1;           // radius
	localparam int R2W  = 2 * RDW;          // radius squared
	localparam int AW   = 2 * CW;           // a = d.d
	localparam int HPW  = CW + WW;          // one term of d.w
	localparam int HW   = 2 * CW + 3;       // h = d.w
	localparam int HAW  = 2 * CW + 2;       // |h|
	localparam int SQW  = 2 * CW + 1;       // one term of w.w
	localparam int CSW  = 2 * CW + 4;       // c
	localparam int CAW  = 2 * CW + 2;       // |c|
	localparam int HHW  = 2 * HAW;          // h*h
	localparam int ACW  = AW + CAW;         // a*|c|
	localparam int DW   = HHW + 1;          // discriminant
	localparam int RW   = 2 * ((DW + 2 * FW + 1) / 2); // sqrt radicand, even
	localparam int SW   = RW / 2;           // root bits = sqrt cells
	localparam int RMW  = SW + 1;           // sqrt partial remainder
	localparam int NW   = ((HW + FW > SW + 1) ? HW + FW : SW + 1) + 1; // numerator
	localparam int NL   = (NW + 1) / 2;     // low half of numerator
	localparam int NH   = NW - NL;          // high half of numerator
	localparam int PLW  = CW + NL + 1;
	localparam int PHW  = CW + NH;
	localparam int PW   = CW + NW;          // dir * numerator
	localparam int QB   = OW + 2;           // quotient bits kept = divide cells
	localparam int TW   = PW - QB;          // dividend bits above the quotient
	localparam int PSW  = QB + 3;           // point before saturation
	localparam int CO_LAT = QB + 6;         // pipeline stages in one coordinate unit

	localparam int IN_TDW  = ((3 * CW + 7) / 8) * 8;
	localparam int OUT_TDW = ((3 * OW + 7) / 8) * 8;

	typedef enum logic [2:0] {
		REG_EYE_X    = 3'd0,
		REG_EYE_Y    = 3'd1,
		REG_EYE_Z    = 3'd2,
		REG_CENTER_X = 3'd3,
		REG_CENTER_Y = 3'd4,
		REG_CENTER_Z = 3'd5,
		REG_RADIUS   = 3'd6
	} cfg_reg_t;

	// one beat moving down the square-root row
	typedef struct packed {
		logic                 vld;
		logic                 hit;
		logic                 tangent;
		logic [RW-1:0]        rad;
		logic [RMW-1:0]       rem;
		logic [SW-1:0]        root;
		logic [AW-1:0]        a;
		logic signed [HW-1:0] h;
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] dz;
	} sq_t;

	// one beat moving down a divider row
	typedef struct packed {
		logic [AW-1:0] a;
		logic [AW-1:0] rem;
		logic [QB-1:0] num;
		logic [QB-1:0] quot;
		logic          neg;
		logic          ovf;
	} dv_t;

endpackage

// ----- rtl/ray_sphere_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_sphere_intersect: ray against one sphere, hit point in signed Q16.8
// Quadratic set-up, a row of square-root cells, three rows of divide cells.
// ----------------------------------------------------------------------------
// Takes one ray direction per clock while s_tready is high and returns one
// result beat per ray, in order. The pipe is 5 set-up stages, 43 square-root
// cells, 1 numerator stage and 32 stages per coordinate (split multiply,
// magnitude, 26 divide cells, sign fix and clamp). Every stage advances
// together; when the output beat is not taken the whole pipe holds, so
// throughput is one ray per cycle while m_tready stays high. The smaller root
// is reported even when it lies behind the eye; a zero direction or a
// negative discriminant is a miss with all points zero. Write eye, center and
// radius only while no ray is in flight.
module ray_sphere_intersect import rsi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [IN_TDW-1:0]  s_tdata,   // dir_x, dir_y, dir_z
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_TDW-1:0] m_tdata,   // point_x, point_y, point_z
	output logic [1:0]         m_tuser,   // hit, tangent
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [CW-1:0]      cfg_data
);

	logic signed [CW-1:0] eye_x_q, eye_y_q, eye_z_q;
	logic signed [CW-1:0] center_x_q, center_y_q, center_z_q;
	logic [RDW-1:0]       radius_q;

	logic                 en;
	logic signed [CW-1:0] dx, dy, dz;
	logic signed [WW-1:0] wx, wy, wz;

	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_sn;
	logic signed [CW-1:0]  dx_s1, dy_s1, dz_s1, dx_s2, dy_s2, dz_s2;
	logic signed [CW-1:0]  dx_s3, dy_s3, dz_s3, dx_s4, dy_s4, dz_s4;
	logic signed [CW-1:0]  dx_s5, dy_s5, dz_s5, dx_sn, dy_sn, dz_sn;
	logic [AW-1:0]         sqx_s1, sqy_s1, sqz_s1;
	logic signed [HPW-1:0] hpx_s1, hpy_s1, hpz_s1;
	logic [SQW-1:0]        wsx_s1, wsy_s1, wsz_s1;
	logic [R2W-1:0]        r2_s1;
	logic [AW-1:0]         a_s2, a_s3, a_s4, a_s5, a_sn;
	logic signed [HW-1:0]  h_s2, h_s3, h_s4, h_s5;
	logic signed [CSW-1:0] c_s2;
	logic [HAW-1:0]        habs_s3;
	logic [CAW-1:0]        cabs_s3;
	logic                  cpos_s3, cpos_s4;
	logic [HHW-1:0]        hh_s4;
	logic [ACW-1:0]        ac_s4;
	logic [DW-1:0]         disc_s5;
	logic                  hit_s5, hit_sn, tan_sn;
	logic signed [NW-1:0]  num_sn;

	sq_t sq [0:SW];

	logic                 fl_vld_q [0:CO_LAT-1];
	logic                 fl_hit_q [0:CO_LAT-1];
	logic                 fl_tan_q [0:CO_LAT-1];
	logic signed [OW-1:0] px, py, pz;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_x_q    <= CW'(0);
			eye_y_q    <= CW'(0);
			eye_z_q    <= CW'(300);
			center_x_q <= CW'(0);
			center_y_q <= -CW'(300);
			center_z_q <= -CW'(200);
			radius_q   <= RDW'(200);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_EYE_X:    eye_x_q    <= cfg_data;
				REG_EYE_Y:    eye_y_q    <= cfg_data;
				REG_EYE_Z:    eye_z_q    <= cfg_data;
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				REG_CENTER_Z: center_z_q <= cfg_data;
				REG_RADIUS:   radius_q   <= cfg_data[RDW-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		dx = s_tdata[CW-1:0];
		dy = s_tdata[2*CW-1:CW];
		dz = s_tdata[3*CW-1:2*CW];
		wx = WW'(eye_x_q) - WW'(center_x_q);
		wy = WW'(eye_y_q) - WW'(center_y_q);
		wz = WW'(eye_z_q) - WW'(center_z_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_sn <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_sn <= sq[SW].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// products
			dx_s1  <= dx;
			dy_s1  <= dy;
			dz_s1  <= dz;
			sqx_s1 <= AW'(dx * dx);
			sqy_s1 <= AW'(dy * dy);
			sqz_s1 <= AW'(dz * dz);
			hpx_s1 <= HPW'(dx * wx);
			hpy_s1 <= HPW'(dy * wy);
			hpz_s1 <= HPW'(dz * wz);
			wsx_s1 <= SQW'(wx * wx);
			wsy_s1 <= SQW'(wy * wy);
			wsz_s1 <= SQW'(wz * wz);
			r2_s1  <= R2W'(radius_q * radius_q);
			// sums
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			dz_s2 <= dz_s1;
			a_s2  <= sqx_s1 + sqy_s1 + sqz_s1;
			h_s2  <= HW'(hpx_s1) + HW'(hpy_s1) + HW'(hpz_s1);
			c_s2  <= CSW'(wsx_s1) + CSW'(wsy_s1) + CSW'(wsz_s1) - CSW'(r2_s1);
			// magnitudes
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			dz_s3   <= dz_s2;
			a_s3    <= a_s2;
			h_s3    <= h_s2;
			habs_s3 <= HAW'(h_s2[HW-1] ? -h_s2 : h_s2);
			cabs_s3 <= CAW'(c_s2[CSW-1] ? -c_s2 : c_s2);
			cpos_s3 <= !c_s2[CSW-1] && (c_s2 != '0);
			// square of h, and a*|c|
			dx_s4   <= dx_s3;
			dy_s4   <= dy_s3;
			dz_s4   <= dz_s3;
			a_s4    <= a_s3;
			h_s4    <= h_s3;
			hh_s4   <= habs_s3 * habs_s3;
			ac_s4   <= a_s3 * cabs_s3;
			cpos_s4 <= cpos_s3;
			// discriminant
			dx_s5   <= dx_s4;
			dy_s5   <= dy_s4;
			dz_s5   <= dz_s4;
			a_s5    <= a_s4;
			h_s5    <= h_s4;
			disc_s5 <= cpos_s4 ? DW'(hh_s4) - DW'(ac_s4) : DW'(hh_s4) + DW'(ac_s4);
			hit_s5  <= (a_s4 != '0) && !(cpos_s4 && (ac_s4 > hh_s4));
		end
	end

	always_comb begin
		sq[0].vld     = vld_s5;
		sq[0].hit     = hit_s5;
		sq[0].tangent = hit_s5 && (disc_s5 == '0);
		sq[0].rad     = RW'(disc_s5) << (2 * FW);
		sq[0].rem     = '0;
		sq[0].root    = '0;
		sq[0].a       = a_s5;
		sq[0].h       = h_s5;
		sq[0].dx      = dx_s5;
		sq[0].dy      = dy_s5;
		sq[0].dz      = dz_s5;
	end

	for (genvar i = 0; i < SW; i++) begin : g_sqrt
		rsi_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (sq[i]),
			.q      (sq[i+1])
		);
	end

	// numerator of the smaller root: -h*2^FW - sqrt(D*2^(2*FW))
	always_ff @(posedge clk) begin
		if (en) begin
			num_sn <= -($signed(NW'(sq[SW].h)) <<< FW) - $signed(NW'(sq[SW].root));
			a_sn   <= sq[SW].a;
			dx_sn  <= sq[SW].dx;
			dy_sn  <= sq[SW].dy;
			dz_sn  <= sq[SW].dz;
			hit_sn <= sq[SW].hit;
			tan_sn <= sq[SW].tangent;
		end
	end

	rsi_coord u_coord_x (
		.clk (clk), .en (en), .dir (dx_sn), .num (num_sn), .a (a_sn),
		.eye (eye_x_q), .point (px)
	);

	rsi_coord u_coord_y (
		.clk (clk), .en (en), .dir (dy_sn), .num (num_sn), .a (a_sn),
		.eye (eye_y_q), .point (py)
	);

	rsi_coord u_coord_z (
		.clk (clk), .en (en), .dir (dz_sn), .num (num_sn), .a (a_sn),
		.eye (eye_z_q), .point (pz)
	);

	// flags ride alongside the coordinate units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CO_LAT; i++) begin
				fl_vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			fl_vld_q[0] <= vld_sn;
			for (int i = 1; i < CO_LAT; i++) begin
				fl_vld_q[i] <= fl_vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_hit_q[0] <= hit_sn;
			fl_tan_q[0] <= tan_sn;
			for (int i = 1; i < CO_LAT; i++) begin
				fl_hit_q[i] <= fl_hit_q[i-1];
				fl_tan_q[i] <= fl_tan_q[i-1];
			end
		end
	end

	always_comb begin
		m_tvalid = fl_vld_q[CO_LAT-1];
		m_tuser  = {fl_tan_q[CO_LAT-1], fl_hit_q[CO_LAT-1]};
		m_tdata  = '0;
		if (fl_hit_q[CO_LAT-1]) begin
			m_tdata[OW-1:0]      = px;
			m_tdata[2*OW-1:OW]   = py;
			m_tdata[3*OW-1:2*OW] = pz;
		end
	end

endmodule

// ----- rtl/rsi_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// rsi_sqrt_cell: one digit of the integer square root
// Takes two radicand bits, decides one root bit, registers the beat.
// ----------------------------------------------------------------------------
module rsi_sqrt_cell import rsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  sq_t  d,
	output sq_t  q
);

	logic [RMW+1:0] t;
	logic [RMW+1:0] trial;
	logic           ge;
	sq_t            nx;
	sq_t            dat_s1;
	logic           vld_s1;

	always_comb begin
		t     = {d.rem, d.rad[RW-1 -: 2]};
		trial = {1'b0, d.root, 2'b01};
		ge    = (t >= trial);
		nx    = d;
		nx.rad  = {d.rad[RW-3:0], 2'b00};
		nx.rem  = ge ? RMW'(t - trial) : RMW'(t);
		nx.root = {d.root[SW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1 <= nx;
		end
	end

	always_comb begin
		q     = dat_s1;
		q.vld = vld_s1;
	end

endmodule

// ----- rtl/rsi_div_cell.sv -----
// ----------------------------------------------------------------------------
// rsi_div_cell: one step of restoring division
// Brings down one dividend bit, decides one quotient bit, registers the beat.
// ----------------------------------------------------------------------------
module rsi_div_cell import rsi_pkg::*; (
	input  logic clk,
	input  logic en,
	input  dv_t  d,
	output dv_t  q
);

	logic [AW:0] t;
	logic        ge;
	dv_t         nx;
	dv_t         dat_s1;

	always_comb begin
		t  = {d.rem, d.num[QB-1]};
		ge = (t >= {1'b0, d.a});
		nx = d;
		nx.rem  = ge ? AW'(t - {1'b0, d.a}) : AW'(t);
		nx.num  = {d.num[QB-2:0], 1'b0};
		nx.quot = {d.quot[QB-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1 <= nx;
		end
	end

	assign q = dat_s1;

endmodule

// ----- rtl/rsi_coord.sv -----
// ----------------------------------------------------------------------------
// rsi_coord: one hit point coordinate, eye + floor(dir * num / a), saturated
// Split multiply, magnitude, a row of divide cells, then sign fix and clamp.
// ----------------------------------------------------------------------------
module rsi_coord import rsi_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [CW-1:0] dir,
	input  logic signed [NW-1:0] num,
	input  logic [AW-1:0]        a,
	input  logic signed [CW-1:0] eye,
	output logic signed [OW-1:0] point
);

	localparam logic signed [PSW-1:0] P_MAX = {{(PSW-OW+1){1'b0}}, {(OW-1){1'b1}}};
	localparam logic signed [PSW-1:0] P_MIN = ~P_MAX;

	logic signed [PLW-1:0] pl_s1;
	logic signed [PHW-1:0] ph_s1;
	logic [AW-1:0]         a_s1, a_s2, a_s3;
	logic signed [PW-1:0]  prod_s2;
	logic [PW-1:0]         abs_s3;
	logic                  neg_s3;
	dv_t                   dv_s4;
	dv_t                   dv [0:QB];
	logic [TW-1:0]         top;
	logic [QB:0]           qmag;
	logic signed [QB+1:0]  q_f1;
	logic                  ovf_f1, neg_f1;
	logic signed [PSW-1:0] p;
	logic signed [OW-1:0]  point_f2;

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= PLW'(dir * $signed({1'b0, num[NL-1:0]}));
			ph_s1 <= PHW'(dir * $signed(num[NW-1:NL]));
			a_s1  <= a;
			prod_s2 <= (PW'(ph_s1) <<< NL) + PW'(pl_s1);
			a_s2    <= a_s1;
			neg_s3  <= prod_s2[PW-1];
			abs_s3  <= prod_s2[PW-1] ? PW'(-prod_s2) : PW'(prod_s2);
			a_s3    <= a_s2;
		end
	end

	// quotient of 2^QB or more saturates whatever the eye is
	always_comb begin
		top = abs_s3[PW-1:QB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s4.a    <= a_s3;
			dv_s4.ovf  <= (top >= TW'(a_s3));
			dv_s4.rem  <= AW'(top);
			dv_s4.num  <= abs_s3[QB-1:0];
			dv_s4.quot <= '0;
			dv_s4.neg  <= neg_s3;
		end
	end

	assign dv[0] = dv_s4;

	for (genvar i = 0; i < QB; i++) begin : g_div
		rsi_div_cell u_cell (
			.clk (clk),
			.en  (en),
			.d   (dv[i]),
			.q   (dv[i+1])
		);
	end

	// floor for a negative dividend rounds the magnitude up
	always_comb begin
		qmag = {1'b0, dv[QB].quot} + (QB+1)'(dv[QB].neg && (dv[QB].rem != '0));
		p    = ($signed(PSW'(eye)) <<< FW) + PSW'(q_f1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_f1   <= dv[QB].neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
			ovf_f1 <= dv[QB].ovf;
			neg_f1 <= dv[QB].neg;
			if (ovf_f1) begin
				point_f2 <= neg_f1 ? OW'(P_MIN) : OW'(P_MAX);
			end else if (p > P_MAX) begin
				point_f2 <= OW'(P_MAX);
			end else if (p < P_MIN) begin
				point_f2 <= OW'(P_MIN);
			end else begin
				point_f2 <= OW'(p);
			end
		end
	end

	assign point = point_f2;

endmodule
